// ===== src/tcpl_pkg.sv =====
package tcpl_pkg;

  localparam int TW = 24;
  localparam int IW = 48;
  localparam logic signed [TW-1:0] BASE_TEMP = 24'sd122880;
  localparam logic [TW-1:0] TARGET_BAND = 24'd2048;

  typedef enum logic [1:0] {
    OP_SET_TEMP = 2'd0,
    OP_START    = 2'd1,
    OP_TICK     = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_T0,
    ST_T1,
    ST_T2,
    ST_T3,
    ST_T4,
    ST_T5,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic do_set;
    logic div_step;
    logic div_fin;
    logic t0;
    logic t1;
    logic t2;
    logic t3;
    logic t4;
    logic t5;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       tick_ok;
    logic       div_done;
  } sts_t;

  typedef struct packed {
    logic [22:0] prop_gain;
    logic [22:0] integ_gain;
    logic signed [TW-1:0] drive_high;
    logic signed [TW-1:0] drive_low;
    logic [23:0] loss_rate;
    logic [23:0] heat_gain;
    logic [23:0] sensor_rate;
    logic [15:0] initial_timeout;
  } cfg_t;

  localparam logic [2:0] REG_PROP = 3'd0;
  localparam logic [2:0] REG_INTEG = 3'd1;
  localparam logic [2:0] REG_DHI = 3'd2;
  localparam logic [2:0] REG_DLO = 3'd3;
  localparam logic [2:0] REG_LOSS = 3'd4;
  localparam logic [2:0] REG_HEAT = 3'd5;
  localparam logic [2:0] REG_SENS = 3'd6;
  localparam logic [2:0] REG_TOUT = 3'd7;

endpackage

// ===== src/thermal_cycler_pi_loop_sim.sv =====
// PI-loop heater simulator: one input word per thermal operation, one result
// word back for each.
// Input channel in_*: tdata = {overshoot_ticks, overshoot_temp, ramp_step,
//   hold_ticks, temp_value, operation}; op 0 loads a
//   temperature, 1 starts a segment, 2 runs one tick, 3 reports only.
// Output channel out_*: tdata = sensor_temp, block_temp, target_temp,
//   drive_out, segment_done, elapsed_ticks from the low bit up.
// Configuration over the APB-style cfg_* port, registers at 4*index.
// Sequencing: a tick runs a dispatch state, six datapath steps, then the output
//   load; a segment start runs the one-bit-a-cycle ramp-length divider before
//   its output load; other ops, and a tick after the segment has timed out,
//   go from dispatch straight to the output load. One word is worked on at a
//   time; the next word is taken the cycle after the result loads.
// Reset puts the block, sensor, target and delay line at 30 degrees, the
//   integral and segment state at zero and the gains at their defaults.
// When the receiver stalls, the result waits in the output register and the
//   next input word is still accepted; its result waits until that slot frees.
module thermal_cycler_pi_loop_sim #(
  parameter int DELAY_DEPTH = 4,
  parameter int HOLD_EXTRA_TICKS = 86
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,  // operation, temp_value, hold_ticks, ramp_step,
                                  // overshoot_temp, overshoot_ticks
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata, // sensor_temp, block_temp, target_temp, drive_out,
                                  // segment_done, elapsed_ticks
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  tcpl_pkg::cfg_t cfg;
  tcpl_pkg::cmd_t cmd;
  tcpl_pkg::sts_t sts;
  logic [112:0]   res;
  logic           in_fire;
  logic           out_valid_r;
  logic [112:0]   out_data_r;

  assign cfg_pready = 1'b1;
  assign in_fire = in_tvalid && in_tready;

  tcpl_regs u_regs (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg
  );

  tcpl_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_busy(out_valid_r && !out_tready), .sts,
    .in_ready(in_tready), .cmd
  );

  tcpl_dp #(.DELAY_DEPTH(DELAY_DEPTH), .HOLD_EXTRA_TICKS(HOLD_EXTRA_TICKS)) u_dp (
    .clk, .rst_n, .cfg, .cmd,
    .in_operation(in_tdata[1:0]),
    .in_temp_value(in_tdata[25:2]),
    .in_hold_ticks(in_tdata[41:26]),
    .in_ramp_step(in_tdata[64:42]),
    .in_overshoot_temp(in_tdata[87:65]),
    .in_overshoot_ticks(in_tdata[103:88]),
    .sts, .res
  );

  // output register: loaded when the slot is free or being emptied
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_data_r};

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && !out_tready))
    else $error("result overwrote waiting word");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid)
    else $error("loaded result not shown");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata))
    else $error("stalled result changed");
endmodule

// ===== src/tcpl_regs.sv =====
module tcpl_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [4:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output tcpl_pkg::cfg_t    cfg
);
  tcpl_pkg::cfg_t cfg_r;
  logic [2:0] idx;
  logic wr;

  assign idx = cfg_paddr[4:2];
  assign wr  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain       <= 23'd1228800;
      cfg_r.integ_gain      <= 23'd819;
      cfg_r.drive_high      <= 24'sd1048576;
      cfg_r.drive_low       <= -24'sd368640;
      cfg_r.loss_rate       <= 24'd14680;
      cfg_r.heat_gain       <= 24'd48933;
      cfg_r.sensor_rate     <= 24'd391468;
      cfg_r.initial_timeout <= 16'd28571;
    end else if (wr) begin
      case (idx)
        tcpl_pkg::REG_PROP:  cfg_r.prop_gain       <= cfg_pwdata[22:0];
        tcpl_pkg::REG_INTEG: cfg_r.integ_gain      <= cfg_pwdata[22:0];
        tcpl_pkg::REG_DHI:   cfg_r.drive_high      <= cfg_pwdata[23:0];
        tcpl_pkg::REG_DLO:   cfg_r.drive_low       <= cfg_pwdata[23:0];
        tcpl_pkg::REG_LOSS:  cfg_r.loss_rate       <= cfg_pwdata[23:0];
        tcpl_pkg::REG_HEAT:  cfg_r.heat_gain       <= cfg_pwdata[23:0];
        tcpl_pkg::REG_SENS:  cfg_r.sensor_rate     <= cfg_pwdata[23:0];
        tcpl_pkg::REG_TOUT:  cfg_r.initial_timeout <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tcpl_pkg::REG_PROP:  cfg_prdata = {9'd0, cfg_r.prop_gain};
      tcpl_pkg::REG_INTEG: cfg_prdata = {9'd0, cfg_r.integ_gain};
      tcpl_pkg::REG_DHI:   cfg_prdata = {{8{cfg_r.drive_high[23]}}, cfg_r.drive_high};
      tcpl_pkg::REG_DLO:   cfg_prdata = {{8{cfg_r.drive_low[23]}}, cfg_r.drive_low};
      tcpl_pkg::REG_LOSS:  cfg_prdata = {8'd0, cfg_r.loss_rate};
      tcpl_pkg::REG_HEAT:  cfg_prdata = {8'd0, cfg_r.heat_gain};
      tcpl_pkg::REG_SENS:  cfg_prdata = {8'd0, cfg_r.sensor_rate};
      tcpl_pkg::REG_TOUT:  cfg_prdata = {16'd0, cfg_r.initial_timeout};
      default:             cfg_prdata = 32'd0;
    endcase
  end
endmodule

// ===== src/tcpl_ctrl.sv =====
module tcpl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic               out_busy,
  input  tcpl_pkg::sts_t     sts,
  output logic               in_ready,
  output tcpl_pkg::cmd_t     cmd
);
  tcpl_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= tcpl_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // after input capture the op is known from sts.op in ST_DIV decisions
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcpl_pkg::ST_IDLE: if (in_fire) state_nxt = tcpl_pkg::ST_DIV;
      tcpl_pkg::ST_DIV: begin
        if (sts.op == tcpl_pkg::OP_START) begin
          if (sts.div_done) state_nxt = tcpl_pkg::ST_OUT;
        end else if (sts.op == tcpl_pkg::OP_TICK && sts.tick_ok) begin
          state_nxt = tcpl_pkg::ST_T0;
        end else begin
          state_nxt = tcpl_pkg::ST_OUT;
        end
      end
      tcpl_pkg::ST_T0: state_nxt = tcpl_pkg::ST_T1;
      tcpl_pkg::ST_T1: state_nxt = tcpl_pkg::ST_T2;
      tcpl_pkg::ST_T2: state_nxt = tcpl_pkg::ST_T3;
      tcpl_pkg::ST_T3: state_nxt = tcpl_pkg::ST_T4;
      tcpl_pkg::ST_T4: state_nxt = tcpl_pkg::ST_T5;
      tcpl_pkg::ST_T5: state_nxt = tcpl_pkg::ST_OUT;
      tcpl_pkg::ST_OUT: if (!out_busy) state_nxt = tcpl_pkg::ST_IDLE;
      default: state_nxt = tcpl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      tcpl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load_in = in_fire;
      end
      tcpl_pkg::ST_DIV: begin
        if (sts.op == tcpl_pkg::OP_START) begin
          cmd.div_step = 1'b1;
          cmd.div_fin  = sts.div_done;
        end else if (sts.op == tcpl_pkg::OP_SET_TEMP) begin
          cmd.do_set = 1'b1;
        end
      end
      tcpl_pkg::ST_T0: cmd.t0 = 1'b1;
      tcpl_pkg::ST_T1: cmd.t1 = 1'b1;
      tcpl_pkg::ST_T2: cmd.t2 = 1'b1;
      tcpl_pkg::ST_T3: cmd.t3 = 1'b1;
      tcpl_pkg::ST_T4: cmd.t4 = 1'b1;
      tcpl_pkg::ST_T5: cmd.t5 = 1'b1;
      tcpl_pkg::ST_OUT: cmd.out_load = !out_busy;
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcpl_pkg::ST_T0) |=> (state_r == tcpl_pkg::ST_T1))
    else $error("tick sequence broken");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == tcpl_pkg::ST_DIV))
    else $error("accept did not start work");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != tcpl_pkg::ST_IDLE) |-> !in_ready)
    else $error("ready while busy");
endmodule

// ===== src/tcpl_dp.sv =====
module tcpl_dp #(
  parameter int DELAY_DEPTH = 4,
  parameter int HOLD_EXTRA_TICKS = 86
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tcpl_pkg::cfg_t         cfg,
  input  tcpl_pkg::cmd_t         cmd,
  input  logic [1:0]             in_operation,
  input  logic signed [23:0]     in_temp_value,
  input  logic [15:0]            in_hold_ticks,
  input  logic [22:0]            in_ramp_step,
  input  logic [22:0]            in_overshoot_temp,
  input  logic [15:0]            in_overshoot_ticks,
  output tcpl_pkg::sts_t         sts,
  output logic [112:0]           res
);
  localparam int TW = tcpl_pkg::TW;
  localparam int IW = tcpl_pkg::IW;
  localparam logic [16:0] HOLD_EXTRA = 17'(HOLD_EXTRA_TICKS);

  // captured item
  logic [1:0]          op_r;
  logic signed [TW-1:0] tv_r;
  logic [15:0]         hold_in_r, ovt_in_r;
  logic [22:0]         ramp_in_r, ov_in_r;

  // state
  logic signed [TW-1:0] blk_r, sen_r, tgt_r;
  logic signed [IW-1:0] integ_r;
  logic signed [TW-1:0] dly_r [DELAY_DEPTH];
  logic signed [TW-1:0] setp_r, sovs_r;
  logic [22:0]          step_r;
  logic [15:0]          rlen_r, olen_r, hlen_r, tmr_r, tout_r;
  logic                 reached_r, down_r;
  logic signed [TW-1:0] drive_r;

  // tick temporaries
  logic signed [TW:0]   err_r;
  logic signed [IW+24:0] pa_r;
  logic signed [TW+23:0] pbh_r;  // ki times upper half of integral
  logic [TW+22:0]        pbl_r;  // ki times lower half of integral
  logic signed [IW+24:0] acc_r;

  // sensor update after block settles; done in the output cycle
  logic post_tick_r;
  logic signed [IW+24:0] sp;
  logic signed [TW-1:0] sen_nxt;

  // ramp divider: 25-bit dividend, restoring, one bit a cycle
  logic [24:0]  dq_r;
  logic [23:0]  drem_r;
  logic [4:0]   dcnt_r;
  logic         dstart_r;

  assign sts.op = op_r;
  assign sts.tick_ok = (tmr_r < tout_r);
  assign sts.div_done = !dstart_r && (dcnt_r == 5'd0);

  function automatic logic signed [TW-1:0] sat24(input logic signed [IW+25:0] v);
    if (v > 74'sd8388607) return 24'sh7FFFFF;
    else if (v < -74'sd8388608) return 24'sh800000;
    else return v[TW-1:0];
  endfunction

  // start-segment arithmetic
  logic                 down_c;
  logic signed [TW-1:0] sov_c;
  logic signed [TW+2:0] d_c;
  logic [TW+1:0]        diff_c;
  logic [31:0]          h10_c;
  logic [16:0]          h_c;
  logic [24:0]          rtrial;
  logic [24:0]          rshift;

  // floor(11*h/10) = h + floor(h/10); h/10 by reciprocal, exact for 16 bits
  always_comb begin
    down_c = tv_r < blk_r;
    sov_c  = down_c ? -$signed({1'b0, ov_in_r}) : $signed({1'b0, ov_in_r});
    d_c    = 27'(tv_r) + 27'(sov_c) - 27'(tgt_r);
    diff_c = d_c[TW+2] ? 26'(-d_c) : 26'(d_c);
    h10_c  = 32'(hold_in_r) * 32'd52429;
    h_c    = 17'(hold_in_r) + 17'(h10_c[31:19]) + HOLD_EXTRA;
    rshift = {drem_r, dq_r[24]};
    rtrial = rshift - {2'b0, step_r};
  end

  // tick-stage arithmetic
  logic signed [TW-1:0] tgt_c;
  logic [16:0]          ro_sum;
  logic signed [IW+1:0] isum;
  logic signed [IW-1:0] isat;
  logic signed [IW+25:0] pb_c;
  logic signed [IW+25:0] dsum;
  logic signed [TW-1:0] dclamp;
  logic signed [IW+25:0] nb;
  logic signed [TW-1:0] nblk;
  logic [TW:0]          dev;
  logic [16:0]          tsum;

  // floor(g*v/4096) equals arithmetic shift of exact product
  always_comb begin
    ro_sum = 17'(rlen_r) + 17'(olen_r);
    if (tmr_r < rlen_r)
      tgt_c = sat24(down_r ? 74'(tgt_r) - 74'(signed'({1'b0, step_r}))
                           : 74'(tgt_r) + 74'(signed'({1'b0, step_r})));
    else if (17'(tmr_r) < ro_sum)
      tgt_c = sat24(74'(setp_r) + 74'(sovs_r));
    else
      tgt_c = setp_r;
    isum  = 50'(integ_r) + 50'(err_r);
    if (isum > 50'sh0_7FFF_FFFF_FFFF) isat = 48'sh7FFF_FFFF_FFFF;
    else if (isum < -50'sh0_8000_0000_0000) isat = 48'sh8000_0000_0000;
    else isat = isum[IW-1:0];
    pb_c = (74'(pbh_r) <<< 24) + 74'($signed({1'b0, pbl_r}));
    dsum = 74'(pa_r >>> 12) + (pb_c >>> 12);
    if (dsum > 74'(cfg.drive_high)) dclamp = cfg.drive_high;
    else if (dsum < 74'(cfg.drive_low)) dclamp = cfg.drive_low;
    else dclamp = dsum[TW-1:0];
    nb   = 74'(blk_r) + 74'(acc_r >>> 24);
    nblk = sat24(nb);
    dev  = (blk_r >= setp_r) ? 25'(26'(blk_r) - 26'(setp_r)) : 25'(26'(setp_r) - 26'(blk_r));
    tsum = 17'(tmr_r) + 17'(hlen_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r <= in_operation; tv_r <= in_temp_value; hold_in_r <= in_hold_ticks;
      ramp_in_r <= in_ramp_step; ov_in_r <= in_overshoot_temp; ovt_in_r <= in_overshoot_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_r <= tcpl_pkg::BASE_TEMP; sen_r <= tcpl_pkg::BASE_TEMP; tgt_r <= tcpl_pkg::BASE_TEMP;
      for (int k = 0; k < DELAY_DEPTH; k++) dly_r[k] <= tcpl_pkg::BASE_TEMP;
      integ_r <= '0; setp_r <= '0; sovs_r <= '0; step_r <= '0;
      rlen_r <= '0; olen_r <= '0; hlen_r <= '0; tmr_r <= '0; tout_r <= '0;
      reached_r <= 1'b0; down_r <= 1'b0; drive_r <= '0;
      dcnt_r <= '0; dstart_r <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        drive_r <= '0;
        dstart_r <= 1'b1;
      end
      if (cmd.do_set) begin
        blk_r <= tv_r; sen_r <= tv_r; tgt_r <= tv_r;
        for (int k = 0; k < DELAY_DEPTH; k++) dly_r[k] <= tv_r;
      end
      if (cmd.div_step) begin
        if (dstart_r) begin
          dstart_r <= 1'b0;
          dq_r   <= (diff_c > 26'd33554431) ? 25'h1FFFFFF : 25'(diff_c);
          drem_r <= '0;
          dcnt_r <= 5'd25;
          step_r <= ramp_in_r;
          // ceil via (diff + step - 1) handled by remainder check at end
        end else if (dcnt_r != 5'd0) begin
          dcnt_r <= dcnt_r - 5'd1;
          if (!rtrial[24]) begin
            drem_r <= rtrial[23:0]; dq_r <= {dq_r[23:0], 1'b1};
          end else begin
            drem_r <= rshift[23:0]; dq_r <= {dq_r[23:0], 1'b0};
          end
        end
      end
      if (cmd.div_fin) begin
        down_r <= down_c; sovs_r <= sov_c; setp_r <= tv_r;
        olen_r <= ovt_in_r;
        hlen_r <= h_c[16] ? 16'hFFFF : h_c[15:0];
        if (step_r == 23'd0) rlen_r <= '0;
        else if ((26'(dq_r) + 26'(drem_r != 24'd0)) > 26'd65535) rlen_r <= 16'hFFFF;
        else rlen_r <= 16'(dq_r + 25'(drem_r != 24'd0));
        tmr_r <= '0; tout_r <= cfg.initial_timeout; reached_r <= 1'b0;
      end
      if (cmd.t0) begin
        tgt_r <= tgt_c;
      end
      if (cmd.t1) begin
        err_r <= 25'(tgt_r) - 25'(dly_r[DELAY_DEPTH-1]);
      end
      if (cmd.t2) begin
        integ_r <= isat;
        pa_r  <= 73'($signed({1'b0, cfg.prop_gain})) * 73'(err_r);
        pbh_r <= 48'($signed({1'b0, cfg.integ_gain})) * 48'($signed(isat[IW-1:24]));
        pbl_r <= 47'(cfg.integ_gain) * 47'(isat[23:0]);
      end
      if (cmd.t3) begin
        drive_r <= dclamp;
      end
      if (cmd.t4) begin
        acc_r <= 73'($signed({1'b0, cfg.heat_gain})) * 73'(drive_r)
               - 73'($signed({1'b0, cfg.loss_rate})) * 73'(blk_r);
      end
      if (cmd.t5) begin
        blk_r <= nblk;
        dly_r[0] <= nblk;
        for (int k = 1; k < DELAY_DEPTH; k++) dly_r[k] <= dly_r[k-1];
        tmr_r <= tmr_r + 16'd1;
      end
      if (cmd.out_load && op_r == tcpl_pkg::OP_TICK && post_tick_r) begin
        sen_r <= sen_nxt;
        if (dev < 25'(tcpl_pkg::TARGET_BAND) && !reached_r) begin
          tout_r <= tsum[16] ? 16'hFFFF : tsum[15:0];
          reached_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) post_tick_r <= 1'b0;
    else if (cmd.t5) post_tick_r <= 1'b1;
    else if (cmd.out_load) post_tick_r <= 1'b0;
  end
  always_comb begin
    sp = 73'($signed({1'b0, cfg.sensor_rate})) * 73'(26'(blk_r) - 26'(sen_r));
    sen_nxt = sat24(74'(sen_r) + 74'(sp >>> 24));
  end

  logic [15:0] tmr_o;
  logic        done_o;
  logic signed [TW-1:0] sen_o;
  always_comb begin
    sen_o = (op_r == tcpl_pkg::OP_TICK && post_tick_r) ? sen_nxt : sen_r;
    tmr_o = tmr_r;
    done_o = (post_tick_r && dev < 25'(tcpl_pkg::TARGET_BAND) && !reached_r)
             ? ((tsum[16] ? 16'hFFFF : tsum[15:0]) <= tmr_r) : (tmr_r >= tout_r);
  end
  assign res = {tmr_o, done_o, drive_r, tgt_r, blk_r, sen_o};
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // DUT signals
  // ---------------------------------------------------------------------------
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata = '0;  // operation, temp_value, hold_ticks, ramp_step,
                                // overshoot_temp, overshoot_ticks
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;  // sensor_temp, block_temp, target_temp, drive_out,
                            // segment_done, elapsed_ticks
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [4:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  thermal_cycler_pi_loop_sim dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // ---------------------------------------------------------------------------
  // Word formats
  // ---------------------------------------------------------------------------
  typedef struct packed {
    tcpl_pkg::op_t op;
    logic [23:0]   temp;
    logic [15:0]   hold;
    logic [22:0]   ramp;
    logic [22:0]   ovs_temp;
    logic [15:0]   ovs_ticks;
  } cmd_word_t;

  typedef struct packed {
    logic [23:0] sensor;
    logic [23:0] blk;
    logic [23:0] target;
    logic [23:0] drive;
    logic        done;
    logic [15:0] elapsed;
  } heat_word_t;

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the heater, controller and settings
  // ---------------------------------------------------------------------------
  localparam int    LAG_DEPTH  = 4;
  localparam int    HOLD_EXTRA = 86;
  localparam longint T24_MAX   = 64'sd8388607;
  localparam longint T24_MIN   = -64'sd8388608;
  localparam longint I48_MAX   = 64'sd140737488355327;
  localparam longint I48_MIN   = -64'sd140737488355328;

  longint m_kp, m_ki, m_dhi, m_dlo, m_loss, m_heat, m_sens, m_tout;
  longint m_blk, m_sensor, m_target, m_integ;
  longint m_lag [LAG_DEPTH];
  longint m_setp, m_ovs, m_step;
  longint m_ramp_len, m_ovs_len, m_hold_len, m_timer, m_timeout;
  bit     m_reached, m_down;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  // floor(a*b / 2^n); a, b are 64-bit values so the product fits 128 bits
  function automatic longint mul_floor(longint a, longint b, int n);
    logic signed [127:0] p;
    p = 128'(signed'(a)) * 128'(signed'(b));
    return longint'(p >>> n);
  endfunction

  function automatic void heater_load(longint t);
    m_blk = t;
    m_sensor = t;
    m_target = t;
    for (int k = 0; k < LAG_DEPTH; k++) m_lag[k] = t;
  endfunction

  function automatic void heater_reset();
    m_kp = 1228800; m_ki = 819; m_dhi = 1048576; m_dlo = -368640;
    m_loss = 14680; m_heat = 48933; m_sens = 391468; m_tout = 28571;
    heater_load(122880);
    m_integ = 0;
    m_setp = 0; m_ovs = 0; m_step = 0;
    m_ramp_len = 0; m_ovs_len = 0; m_hold_len = 0;
    m_timer = 0; m_timeout = 0;
    m_reached = 0; m_down = 0;
  endfunction

  function automatic void heater_config(int idx, logic [31:0] v);
    case (idx)
      tcpl_pkg::REG_PROP:  m_kp   = longint'(v[22:0]);
      tcpl_pkg::REG_INTEG: m_ki   = longint'(v[22:0]);
      tcpl_pkg::REG_DHI:   m_dhi  = longint'(signed'(v[23:0]));
      tcpl_pkg::REG_DLO:   m_dlo  = longint'(signed'(v[23:0]));
      tcpl_pkg::REG_LOSS:  m_loss = longint'(v[23:0]);
      tcpl_pkg::REG_HEAT:  m_heat = longint'(v[23:0]);
      tcpl_pkg::REG_SENS:  m_sens = longint'(v[23:0]);
      tcpl_pkg::REG_TOUT:  m_tout = longint'(v[15:0]);
      default: ;
    endcase
  endfunction

  // one controller tick; returns clamped drive
  function automatic longint heater_tick();
    longint err, drv, acc;
    err = m_target - m_lag[LAG_DEPTH-1];
    m_integ = clip(m_integ + err, I48_MIN, I48_MAX);
    drv = mul_floor(m_kp, err, 12) + mul_floor(m_ki, m_integ, 12);
    if (drv > m_dhi) drv = m_dhi;
    else if (drv < m_dlo) drv = m_dlo;
    acc = m_heat * drv - m_loss * m_blk;
    m_blk = clip(m_blk + (acc >>> 24), T24_MIN, T24_MAX);
    for (int k = LAG_DEPTH - 1; k > 0; k--) m_lag[k] = m_lag[k-1];
    m_lag[0] = m_blk;
    acc = m_sens * (m_blk - m_sensor);
    m_sensor = clip(m_sensor + (acc >>> 24), T24_MIN, T24_MAX);
    return drv;
  endfunction

  function automatic heat_word_t heater_step(cmd_word_t c);
    heat_word_t r;
    longint tv, drv, h, d, rl, dev;
    tv = longint'(signed'(c.temp));
    drv = 0;
    if (c.op == tcpl_pkg::OP_SET_TEMP) begin
      heater_load(tv);
    end else if (c.op == tcpl_pkg::OP_START) begin
      m_down = tv < m_blk;
      m_ovs = m_down ? -longint'(c.ovs_temp) : longint'(c.ovs_temp);
      m_setp = tv;
      m_step = longint'(c.ramp);
      m_ovs_len = longint'(c.ovs_ticks);
      h = longint'(c.hold) * 11 / 10 + HOLD_EXTRA;
      m_hold_len = h > 65535 ? 65535 : h;
      d = tv + m_ovs - m_target;
      if (d < 0) d = -d;
      rl = m_step > 0 ? (d + m_step - 1) / m_step : 0;
      m_ramp_len = rl > 65535 ? 65535 : rl;
      m_timer = 0;
      m_timeout = m_tout;
      m_reached = 0;
    end else if (c.op == tcpl_pkg::OP_TICK && m_timer < m_timeout) begin
      if (m_timer < m_ramp_len)
        m_target = clip(m_down ? m_target - m_step : m_target + m_step, T24_MIN, T24_MAX);
      else if (m_timer < m_ramp_len + m_ovs_len)
        m_target = clip(m_setp + m_ovs, T24_MIN, T24_MAX);
      else
        m_target = m_setp;
      drv = heater_tick();
      m_timer++;
      dev = m_blk - m_setp;
      if (dev < 0) dev = -dev;
      if (dev < 2048 && !m_reached) begin
        m_timeout = m_timer + m_hold_len > 65535 ? 65535 : m_timer + m_hold_len;
        m_reached = 1;
      end
    end
    r.sensor  = m_sensor[23:0];
    r.blk     = m_blk[23:0];
    r.target  = m_target[23:0];
    r.drive   = drv[23:0];
    r.done    = m_timer >= m_timeout;
    r.elapsed = m_timer[15:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Queues and bookkeeping
  // ---------------------------------------------------------------------------
  cmd_word_t  pending_cmds[$];
  heat_word_t expected_heat[$];
  int         mismatches = 0;
  longint     cycle_count = 0;
  bit         idle_in;     // random gaps on the input side
  bit         idle_out;    // random stalls on the output side

  localparam longint CYCLE_LIMIT = 3000000;

  function automatic logic [103:0] pack_cmd(cmd_word_t c);
    return {c.ovs_ticks, c.ovs_temp, c.ramp, c.hold, c.temp, c.op};
  endfunction

  function automatic void add_cmd(cmd_word_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: pops pending commands, runs the predictor on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_heat.insert(expected_heat.size(), heater_step(pending_cmds.pop_front()));
      end
      // one decision per edge; valid stays up until the word goes
      if (!(in_tvalid && !in_tready)) begin
        if (pending_cmds.size() > 0 && !(idle_in && $urandom_range(99) < 30)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pack_cmd(pending_cmds[0]);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compares each result word with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        heat_word_t got, want;
        got.sensor  = out_tdata[23:0];
        got.blk     = out_tdata[47:24];
        got.target  = out_tdata[71:48];
        got.drive   = out_tdata[95:72];
        got.done    = out_tdata[96];
        got.elapsed = out_tdata[112:97];
        if (expected_heat.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result word %h", out_tdata);
        end else begin
          want = expected_heat.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: sensor %h/%h blk %h/%h tgt %h/%h drv %h/%h done %b/%b el %0d/%0d",
                       want.sensor, got.sensor, want.blk, got.blk, want.target, got.target,
                       want.drive, got.drive, want.done, got.done, want.elapsed, got.elapsed);
          end
        end
      end
      out_tready <= !(idle_out && $urandom_range(99) < 30);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Config writes (APB setup + access), only while the block is idle
  // ---------------------------------------------------------------------------
  task automatic cfg_write(int idx, logic [31:0] v);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 5'(idx * 4);
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    heater_config(idx, v);
  endtask

  // wait until all queued words went in and all results came back
  task automatic drain();
    while (pending_cmds.size() > 0 || expected_heat.size() > 0 || in_tvalid)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic cmd_word_t mk(tcpl_pkg::op_t op, logic [23:0] t, logic [15:0] h,
                                   logic [22:0] r, logic [22:0] ot, logic [15:0] on);
    cmd_word_t c;
    c.op = op; c.temp = t; c.hold = h; c.ramp = r; c.ovs_temp = ot; c.ovs_ticks = on;
    return c;
  endfunction

  function automatic void push_tick(int n);
    for (int i = 0; i < n; i++)
      add_cmd(mk(tcpl_pkg::OP_TICK, 24'($urandom), 16'($urandom), 23'($urandom),
                 23'($urandom), 16'($urandom)));
  endfunction

  // a realistic segment: setpoint near the current range, modest ramp, short hold
  function automatic void push_segment(int ticks);
    int base;
    base = $urandom_range(20, 100) * 4096 + $urandom_range(4095);
    add_cmd(mk(tcpl_pkg::OP_START, 24'(base), 16'($urandom_range(40)),
               23'($urandom_range(8) == 0 ? 0 : $urandom_range(16000)),
               23'($urandom_range(3) * 2048 + $urandom_range(2047)),
               16'($urandom_range(10))));
    push_tick(ticks);
  endfunction

  function automatic cmd_word_t random_cmd();
    cmd_word_t c;
    c = mk(tcpl_pkg::op_t'($urandom_range(3)), 24'($urandom), 16'($urandom),
           23'($urandom), 23'($urandom), 16'($urandom));
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    idle_in = 1'b1;
    idle_out = 1'b1;
    heater_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: tick before any segment (timer already done), report-only,
    // extremes of temperature and of all segment fields
    add_cmd(mk(tcpl_pkg::OP_TICK, '0, '0, '0, '0, '0));
    add_cmd(mk(tcpl_pkg::OP_NONE, 24'hFFFFFF, 16'hFFFF, 23'h7FFFFF, 23'h7FFFFF, 16'hFFFF));
    add_cmd(mk(tcpl_pkg::OP_SET_TEMP, 24'h7FFFFF, '0, '0, '0, '0));
    add_cmd(mk(tcpl_pkg::OP_START, 24'h800000, 16'hFFFF, 23'h7FFFFF, 23'h7FFFFF, 16'hFFFF));
    push_tick(3);
    add_cmd(mk(tcpl_pkg::OP_SET_TEMP, 24'h800000, '0, '0, '0, '0));
    add_cmd(mk(tcpl_pkg::OP_START, 24'h7FFFFF, '0, 23'd1, '0, '0));       // long ramp up
    push_tick(3);
    add_cmd(mk(tcpl_pkg::OP_SET_TEMP, 24'd122880, '0, '0, '0, '0));
    add_cmd(mk(tcpl_pkg::OP_START, 24'd204800, 16'd5, '0, 23'd4096, 16'd2));    // jump
    push_tick(4);
    add_cmd(mk(tcpl_pkg::OP_START, 24'd40960, 16'd10, 23'd2048, 23'd4096, 16'd3)); // ramp down
    push_tick(4);
    drain();

    // every register: extremes first, then defaults-ish
    cfg_write(tcpl_pkg::REG_PROP, 32'h7FFFFF);
    cfg_write(tcpl_pkg::REG_INTEG, 32'h7FFFFF);
    cfg_write(tcpl_pkg::REG_DHI, 32'h7FFFFF);
    cfg_write(tcpl_pkg::REG_DLO, 32'h800000);
    cfg_write(tcpl_pkg::REG_LOSS, 32'hFFFFFF);
    cfg_write(tcpl_pkg::REG_HEAT, 32'hFFFFFF);
    cfg_write(tcpl_pkg::REG_SENS, 32'hFFFFFF);
    cfg_write(tcpl_pkg::REG_TOUT, 32'hFFFF);
    push_segment(20);
    for (int i = 0; i < 20; i++) add_cmd(random_cmd());
    drain();

    cfg_write(tcpl_pkg::REG_PROP, 0);
    cfg_write(tcpl_pkg::REG_INTEG, 0);
    cfg_write(tcpl_pkg::REG_DHI, 0);
    cfg_write(tcpl_pkg::REG_DLO, 0);
    cfg_write(tcpl_pkg::REG_LOSS, 0);
    cfg_write(tcpl_pkg::REG_HEAT, 0);
    cfg_write(tcpl_pkg::REG_SENS, 0);
    cfg_write(tcpl_pkg::REG_TOUT, 0);
    push_segment(8);
    drain();

    // back near the shipped defaults; short timeout lets segments finish
    cfg_write(tcpl_pkg::REG_PROP, 1228800);
    cfg_write(tcpl_pkg::REG_INTEG, 819);
    cfg_write(tcpl_pkg::REG_DHI, 1048576);
    cfg_write(tcpl_pkg::REG_DLO, 32'hFA6000);
    cfg_write(tcpl_pkg::REG_LOSS, 14680);
    cfg_write(tcpl_pkg::REG_HEAT, 200000);
    cfg_write(tcpl_pkg::REG_SENS, 391468);
    cfg_write(tcpl_pkg::REG_TOUT, 300);

    // random: mostly well-formed segments, some noise; one phase with no idling
    for (int p = 0; p < 4; p++) begin
      idle_in  = (p != 2);
      idle_out = (p != 2);
      for (int s = 0; s < 14; s++) begin
        push_segment($urandom_range(10, 40));
        if ($urandom_range(3) == 0) add_cmd(random_cmd());
        if ($urandom_range(7) == 0)
          add_cmd(mk(tcpl_pkg::OP_SET_TEMP, 24'($urandom_range(20, 90) * 4096),
                     '0, '0, '0, '0));
      end
      drain();   // sender holds off until every result is back
      cfg_write(tcpl_pkg::REG_PROP, $urandom_range(400000, 2000000));
      cfg_write(tcpl_pkg::REG_INTEG, $urandom_range(2000));
      cfg_write(tcpl_pkg::REG_TOUT, $urandom_range(50, 400));
    end
    for (int i = 0; i < 40; i++) add_cmd(random_cmd());

    drain();
    if (mismatches == 0 && expected_heat.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
